// File: design/pinproj_pkg.sv
// ----------------------------------------------------------------------------
// pinproj_pkg
// Shared widths, register indexes and reset values for the pinhole projection.
// ----------------------------------------------------------------------------
package pinproj_pkg;

	localparam int COORD_W = 32;
	localparam int COEF_W  = 32;
	localparam int REG_W   = 64;
	localparam int PROD_W  = 64;
	localparam int MAG_W   = 64;
	localparam int QUOT_W  = 33;
	localparam int FRAC_W  = 16;
	localparam int NUM_REGS = 6;
	localparam int IDX_W   = 3;
	// one setup stage plus one stage per quotient bit
	localparam int DIV_LAT = QUOT_W + 1;

	localparam logic [IDX_W-1:0] REG_ROW0_C01 = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW0_C23 = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROW1_C01 = 3'd2;
	localparam logic [IDX_W-1:0] REG_ROW1_C23 = 3'd3;
	localparam logic [IDX_W-1:0] REG_ROW2_C01 = 3'd4;
	localparam logic [IDX_W-1:0] REG_ROW2_C23 = 3'd5;

	localparam logic [REG_W-1:0] RST_ROW0_C01 = 64'h0000_0000_0000_1000;
	localparam logic [REG_W-1:0] RST_ROW0_C23 = 64'h0;
	localparam logic [REG_W-1:0] RST_ROW1_C01 = 64'h0000_1000_0000_0000;
	localparam logic [REG_W-1:0] RST_ROW1_C23 = 64'h0;
	localparam logic [REG_W-1:0] RST_ROW2_C01 = 64'h0;
	localparam logic [REG_W-1:0] RST_ROW2_C23 = 64'h0000_0000_0000_1000;

	localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

	typedef struct packed {
		logic neg_u;
		logic neg_v;
		logic zero;
	} side_t;

endpackage

// File: design/pinproj_div.sv
// ----------------------------------------------------------------------------
// pinproj_div
// Pipelined restoring divider: quot = (num << 16) / den, one bit per stage,
// with a flag when the quotient needs more than 33 bits.
// ----------------------------------------------------------------------------
module pinproj_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic [pinproj_pkg::MAG_W-1:0]     num,
	input  logic [pinproj_pkg::MAG_W-1:0]     den,
	output logic [pinproj_pkg::QUOT_W-1:0]    quot,
	output logic                              ovf
);

	localparam int MW = pinproj_pkg::MAG_W;
	localparam int QW = pinproj_pkg::QUOT_W;
	localparam int FW = pinproj_pkg::FRAC_W;

	logic [MW-1:0] rem_s [0:QW-1];
	logic [FW:0]   num_s [0:QW-FW-1];
	logic [MW-1:0] den_s [0:QW-1];
	logic [QW-1:0] q_s   [0:QW];
	logic          ovf_s [0:QW];

	// quotient needs 34+ bits when (num<<16)>>33 >= den
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= ({{(QW-FW){1'b0}}, num[MW-1:QW-FW]} >= den);
			rem_s[0] <= {{(QW-FW){1'b0}}, num[MW-1:QW-FW]};
			num_s[0] <= num[FW:0];
			den_s[0] <= den;
			q_s[0]   <= '0;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_step
		localparam int K = QW - j;
		logic       nbit;
		logic [MW:0] trial;
		logic       take;
		if (K >= FW) begin : g_bit
			assign nbit = num_s[j-1][K-FW];
		end else begin : g_zero
			assign nbit = 1'b0;
		end
		assign trial = {rem_s[j-1], nbit};
		assign take  = trial >= {1'b0, den_s[j-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[j]   <= {q_s[j-1][QW-2:0], take};
				ovf_s[j] <= ovf_s[j-1];
			end
		end
		// the last stage only delivers quotient bits
		if (j < QW) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= take ? MW'(trial - {1'b0, den_s[j-1]}) : trial[MW-1:0];
					den_s[j] <= den_s[j-1];
				end
			end
		end
		// dividend bits run out after the integer part
		if (j < QW - FW) begin : g_num
			always_ff @(posedge clk) begin
				if (en) begin
					num_s[j] <= num_s[j-1];
				end
			end
		end
	end

	assign quot = q_s[QW];
	assign ovf  = ovf_s[QW];

endmodule

// File: design/pinhole_point_projection_core.sv
// ----------------------------------------------------------------------------
// pinhole_point_projection_core
// Projects a Q16.16 world point through a 3x4 Q20.12 matrix to a Q16.16 pixel.
// ----------------------------------------------------------------------------
//  port group   direction  handshake           beat
//  in_*         in         in_valid/in_ready   point_x, point_y, point_z
//  out_*        out        out_valid/out_ready pixel_u, pixel_v, depth_zero, saturated
//  cfg_*        in         cfg_we              cfg_addr, cfg_wdata
//
// one beat per cycle while the output beat is not held waiting
// stages: products, pair sums, final sum, magnitude, 34 divider stages, output
// the divider (one quotient bit per stage) sets the depth
// reset clears valid bits and loads the identity-like matrix
// the whole pipe holds while the output beat waits, so nothing is lost
module pinhole_point_projection_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [pinproj_pkg::COORD_W-1:0] point_x,
	input  logic signed [pinproj_pkg::COORD_W-1:0] point_y,
	input  logic signed [pinproj_pkg::COORD_W-1:0] point_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [pinproj_pkg::COORD_W-1:0] pixel_u,
	output logic signed [pinproj_pkg::COORD_W-1:0] pixel_v,
	output logic                                 depth_zero,
	output logic                                 saturated,
	input  logic                                 cfg_we,
	input  logic [pinproj_pkg::IDX_W-1:0]        cfg_addr,
	input  logic [pinproj_pkg::REG_W-1:0]        cfg_wdata
);

	localparam int CW = pinproj_pkg::COORD_W;
	localparam int PW = pinproj_pkg::PROD_W;
	localparam int MW = pinproj_pkg::MAG_W;
	localparam int QW = pinproj_pkg::QUOT_W;
	localparam int DL = pinproj_pkg::DIV_LAT;

	logic [pinproj_pkg::REG_W-1:0] mat_q [0:pinproj_pkg::NUM_REGS-1];
	logic en;

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= pinproj_pkg::RST_ROW0_C01;
			mat_q[1] <= pinproj_pkg::RST_ROW0_C23;
			mat_q[2] <= pinproj_pkg::RST_ROW1_C01;
			mat_q[3] <= pinproj_pkg::RST_ROW1_C23;
			mat_q[4] <= pinproj_pkg::RST_ROW2_C01;
			mat_q[5] <= pinproj_pkg::RST_ROW2_C23;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				pinproj_pkg::REG_ROW0_C01: mat_q[0] <= cfg_wdata;
				pinproj_pkg::REG_ROW0_C23: mat_q[1] <= cfg_wdata;
				pinproj_pkg::REG_ROW1_C01: mat_q[2] <= cfg_wdata;
				pinproj_pkg::REG_ROW1_C23: mat_q[3] <= cfg_wdata;
				pinproj_pkg::REG_ROW2_C01: mat_q[4] <= cfg_wdata;
				pinproj_pkg::REG_ROW2_C23: mat_q[5] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4;
	logic [DL-1:0] v_sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_sd <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_sd <= {v_sd[DL-2:0], v_s4};
			out_valid <= v_sd[DL-1];
		end
	end

	// stage 1: products, column 3 times w = 1.0
	logic signed [PW-1:0] prod_s1 [0:2][0:3];
	for (genvar r = 0; r < 3; r++) begin : g_row
		logic signed [CW-1:0] c0, c1, c2, c3;
		assign c0 = mat_q[2*r][CW-1:0];
		assign c1 = mat_q[2*r][2*CW-1:CW];
		assign c2 = mat_q[2*r+1][CW-1:0];
		assign c3 = mat_q[2*r+1][2*CW-1:CW];
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1[r][0] <= PW'(c0 * point_x);
				prod_s1[r][1] <= PW'(c1 * point_y);
				prod_s1[r][2] <= PW'(c2 * point_z);
				prod_s1[r][3] <= {{(PW-CW-16){c3[CW-1]}}, c3, 16'h0};
			end
		end
	end

	// stages 2 to 4: sums, 66 bits exact, then sign and magnitude
	logic signed [PW:0]   pair_s2 [0:2][0:1];
	logic signed [PW+1:0] sum_s3  [0:2];
	logic [MW-1:0]        mag_s4  [0:2];
	logic                 neg_s4  [0:2];

	for (genvar r = 0; r < 3; r++) begin : g_sum
		always_ff @(posedge clk) begin
			if (en) begin
				pair_s2[r][0] <= (PW+1)'(prod_s1[r][0]) + (PW+1)'(prod_s1[r][1]);
				pair_s2[r][1] <= (PW+1)'(prod_s1[r][2]) + (PW+1)'(prod_s1[r][3]);
				sum_s3[r]     <= (PW+2)'(pair_s2[r][0]) + (PW+2)'(pair_s2[r][1]);
				neg_s4[r]     <= sum_s3[r][PW+1];
				mag_s4[r]     <= sum_s3[r][PW+1] ? MW'(-sum_s3[r]) : sum_s3[r][MW-1:0];
			end
		end
	end

	// dividers and side flags
	logic [QW-1:0] qu, qv;
	logic          ovf_u, ovf_v;

	pinproj_div u_div_u (
		.clk(clk), .en(en), .num(mag_s4[0]), .den(mag_s4[2]), .quot(qu), .ovf(ovf_u)
	);
	pinproj_div u_div_v (
		.clk(clk), .en(en), .num(mag_s4[1]), .den(mag_s4[2]), .quot(qv), .ovf(ovf_v)
	);

	pinproj_pkg::side_t side_sd [0:DL-1];
	always_ff @(posedge clk) begin
		if (en) begin
			side_sd[0] <= '{neg_u: neg_s4[0] ^ neg_s4[2], neg_v: neg_s4[1] ^ neg_s4[2],
				zero: (mag_s4[2] == '0)};
			for (int i = 1; i < DL; i++) side_sd[i] <= side_sd[i-1];
		end
	end

	// sign and clamp
	logic [CW-1:0] u_val, v_val;
	logic          u_sat, v_sat;
	pinproj_pkg::side_t sd;
	assign sd = side_sd[DL-1];

	always_comb begin
		if (!sd.neg_u) begin
			u_sat = ovf_u || (qu > QW'(pinproj_pkg::SAT_POS));
			u_val = u_sat ? pinproj_pkg::SAT_POS : qu[CW-1:0];
		end else begin
			u_sat = ovf_u || (qu > QW'(pinproj_pkg::SAT_NEG));
			u_val = u_sat ? pinproj_pkg::SAT_NEG : CW'(-qu[CW-1:0]);
		end
		if (!sd.neg_v) begin
			v_sat = ovf_v || (qv > QW'(pinproj_pkg::SAT_POS));
			v_val = v_sat ? pinproj_pkg::SAT_POS : qv[CW-1:0];
		end else begin
			v_sat = ovf_v || (qv > QW'(pinproj_pkg::SAT_NEG));
			v_val = v_sat ? pinproj_pkg::SAT_NEG : CW'(-qv[CW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_u    <= sd.zero ? '0 : u_val;
			pixel_v    <= sd.zero ? '0 : v_val;
			depth_zero <= sd.zero;
			saturated  <= !sd.zero && (u_sat || v_sat);
		end
	end

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && depth_zero |-> pixel_u == '0 && pixel_v == '0 && !saturated)
		else $error("zero depth with nonzero pixel");
	a_sat_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> pixel_u == pinproj_pkg::SAT_POS ||
		pixel_u == pinproj_pkg::SAT_NEG || pixel_v == pinproj_pkg::SAT_POS ||
		pixel_v == pinproj_pkg::SAT_NEG)
		else $error("saturated flag without clamped pixel");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_u) && $stable(pixel_v))
		else $error("output beat changed under stall");

endmodule
